// ----- sv/smie_pkg.sv -----
package smie_pkg;

  localparam int StackDepth = 16;
  localparam int LocalSlots = 16;
  localparam int SpW = $clog2(StackDepth + 1);
  localparam int SIdxW = $clog2(StackDepth);
  localparam int LIdxW = $clog2(LocalSlots);

  typedef enum logic [4:0] {
    CMD_NOP = 5'd0, CMD_PUSHINT = 5'd1, CMD_LOAD = 5'd2, CMD_STORE = 5'd3,
    CMD_IINC = 5'd4, CMD_IADD = 5'd5, CMD_LADD = 5'd6, CMD_IMUL = 5'd7,
    CMD_LMUL = 5'd8, CMD_POP = 5'd9, CMD_POP2 = 5'd10, CMD_DUP = 5'd11,
    CMD_IFEQ = 5'd12, CMD_IFNE = 5'd13, CMD_IFLT = 5'd14, CMD_IFLE = 5'd15,
    CMD_IFGT = 5'd16, CMD_IFGE = 5'd17, CMD_GOTO = 5'd18, CMD_PUSHNULL = 5'd19
  } cmd_e;

  typedef enum logic [1:0] {
    T_EMPTY = 2'd0, T_INT = 2'd1, T_LONG = 2'd2, T_REF = 2'd3
  } type_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_INDEX = 3'd1, ST_TYPE = 3'd2, ST_UNDER = 3'd3,
    ST_OVER = 3'd4, ST_UNKNOWN = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_MUL, S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic fetch;     // register the operands
    logic execute;   // decide and commit
    logic mul_step;  // next partial product of the long multiply
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_mul;
    logic mul_last;
  } stat_t;

endpackage

// ----- sv/smie_ctrl.sv -----
module smie_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  smie_pkg::stat_t stat_i,
  output smie_pkg::cmd_t  cmd_o
);

  smie_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smie_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      smie_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = smie_pkg::S_READ;
        end
      end
      smie_pkg::S_READ: begin
        cmd_o.fetch = 1'b1;
        state_d = smie_pkg::S_EXEC;
      end
      smie_pkg::S_EXEC: begin
        if (stat_i.needs_mul) begin
          state_d = smie_pkg::S_MUL;
        end else begin
          cmd_o.execute = 1'b1;
          state_d = smie_pkg::S_DONE;
        end
      end
      smie_pkg::S_MUL: begin
        if (stat_i.mul_last) begin
          cmd_o.execute = 1'b1;
          state_d = smie_pkg::S_DONE;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      smie_pkg::S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = smie_pkg::S_IDLE;
        end
      end
      default: state_d = smie_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.capture, cmd_o.fetch, cmd_o.execute, cmd_o.mul_step}) <= 1)
    else $error("controller issued two commands");
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_o)
    else $error("result not presented after execute");
  a_cap_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.fetch)
    else $error("capture not followed by operand read");
`endif

endmodule

// ----- sv/smie_dp.sv -----
module smie_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smie_pkg::cmd_t         cmd_i,
  output smie_pkg::stat_t        stat_o,
  input  logic                   cfg_we_i,
  input  logic [4:0]             cfg_wdata_i,
  input  logic [4:0]             command_i,
  input  logic [7:0]             local_index_i,
  input  logic signed [31:0]     immediate_i,
  output logic [2:0]             status_o,
  output logic                   branch_taken_o,
  output logic signed [31:0]     branch_offset_o,
  output logic [63:0]            top_value_o,
  output logic [1:0]             top_type_o,
  output logic [4:0]             stack_depth_o
);

  localparam int SpW = smie_pkg::SpW;
  localparam int SIdxW = smie_pkg::SIdxW;
  localparam int LIdxW = smie_pkg::LIdxW;

  logic [4:0]  locals_q;
  logic [4:0]  cmd_q;
  logic [7:0]  idx_q;
  logic [31:0] imm_q;

  logic [SpW-1:0] sp_q;
  logic [63:0] stk_q [smie_pkg::StackDepth];
  logic [1:0]  stt_q [smie_pkg::StackDepth];
  logic [63:0] lv_q  [smie_pkg::LocalSlots];
  logic [1:0]  lt_q  [smie_pkg::LocalSlots];

  // Operand registers filled in the read cycle.
  logic [63:0] v1_q, v2_q, lval_q;
  logic [1:0]  t1_q, t2_q, ltyp_q;
  logic        lok_q;

  // Long multiply: three 32x32 partial products accumulated in macc_q, one per mul_step.
  // The high-by-high product falls outside the 64-bit result and is skipped.
  logic [1:0]  mcnt_q;
  logic [63:0] macc_q;

  logic [2:0]  st_q;
  logic        tk_q;
  logic [31:0] off_q;

  // Read path.
  logic [SIdxW-1:0] i1, i2;
  logic [LIdxW-1:0] li;
  logic [8:0] lim;
  always_comb begin
    i1 = SIdxW'(sp_q - SpW'(1));
    i2 = SIdxW'(sp_q - SpW'(2));
    li = idx_q[LIdxW-1:0];
    lim = (9'(locals_q) < 9'(smie_pkg::LocalSlots)) ? 9'(locals_q)
                                                    : 9'(smie_pkg::LocalSlots);
  end

  logic [31:0] pa, pb;
  always_comb begin
    pa = mcnt_q[0] ? v2_q[63:32] : v2_q[31:0];
    pb = mcnt_q[1] ? v1_q[63:32] : v1_q[31:0];
  end
  logic [63:0] prod;
  assign prod = 64'(pa) * 64'(pb);

  assign stat_o.needs_mul = (cmd_q == smie_pkg::CMD_LMUL) && sp_q >= SpW'(2)
                            && t1_q == smie_pkg::T_LONG && t2_q == smie_pkg::T_LONG;
  assign stat_o.mul_last = (mcnt_q == 2'd3);

  // Decision logic.
  logic [2:0]  st;
  logic        tk, push, wr_loc, iinc;
  logic [1:0]  pops;
  logic [63:0] pv;
  logic [1:0]  pt;
  logic        full, lt_s, eq;
  always_comb begin
    st = smie_pkg::ST_OK; tk = 1'b0; push = 1'b0; pops = 2'd0;
    wr_loc = 1'b0; iinc = 1'b0; pv = '0; pt = smie_pkg::T_EMPTY;
    full = sp_q >= SpW'(smie_pkg::StackDepth);
    eq = v2_q[31:0] == v1_q[31:0];
    lt_s = $signed(v2_q[31:0]) < $signed(v1_q[31:0]);
    case (cmd_q)
      smie_pkg::CMD_NOP: ;
      smie_pkg::CMD_PUSHINT, smie_pkg::CMD_PUSHNULL: begin
        if (full) st = smie_pkg::ST_OVER;
        else begin
          push = 1'b1;
          pv = (cmd_q == smie_pkg::CMD_PUSHINT) ? {32'd0, imm_q} : 64'd0;
          pt = (cmd_q == smie_pkg::CMD_PUSHINT) ? smie_pkg::T_INT : smie_pkg::T_REF;
        end
      end
      smie_pkg::CMD_LOAD: begin
        if (!lok_q) st = smie_pkg::ST_INDEX;
        else if (full) st = smie_pkg::ST_OVER;
        else if (ltyp_q == smie_pkg::T_EMPTY) st = smie_pkg::ST_TYPE;
        else begin push = 1'b1; pv = lval_q; pt = ltyp_q; end
      end
      smie_pkg::CMD_STORE: begin
        if (!lok_q) st = smie_pkg::ST_INDEX;
        else if (sp_q < SpW'(1)) st = smie_pkg::ST_UNDER;
        else begin wr_loc = 1'b1; pops = 2'd1; end
      end
      smie_pkg::CMD_IINC: begin
        if (!lok_q) st = smie_pkg::ST_INDEX;
        else if (ltyp_q != smie_pkg::T_INT) st = smie_pkg::ST_TYPE;
        else iinc = 1'b1;
      end
      smie_pkg::CMD_IADD, smie_pkg::CMD_LADD, smie_pkg::CMD_IMUL, smie_pkg::CMD_LMUL: begin
        pt = (cmd_q == smie_pkg::CMD_IADD || cmd_q == smie_pkg::CMD_IMUL)
             ? smie_pkg::T_INT : smie_pkg::T_LONG;
        if (sp_q < SpW'(2)) st = smie_pkg::ST_UNDER;
        else if (t1_q != pt || t2_q != pt) st = smie_pkg::ST_TYPE;
        else begin
          pops = 2'd2; push = 1'b1;
          case (cmd_q)
            smie_pkg::CMD_IADD: pv = {32'd0, v2_q[31:0] + v1_q[31:0]};
            smie_pkg::CMD_IMUL: pv = {32'd0, prod[31:0]};
            smie_pkg::CMD_LADD: pv = v2_q + v1_q;
            default:            pv = macc_q;
          endcase
        end
      end
      smie_pkg::CMD_POP: begin
        if (sp_q < SpW'(1)) st = smie_pkg::ST_UNDER;
        else if (t1_q == smie_pkg::T_LONG) st = smie_pkg::ST_TYPE;
        else pops = 2'd1;
      end
      smie_pkg::CMD_POP2: begin
        if (sp_q < SpW'(1)) st = smie_pkg::ST_UNDER;
        else if (t1_q == smie_pkg::T_LONG) pops = 2'd1;
        else if (sp_q < SpW'(2)) st = smie_pkg::ST_UNDER;
        else if (t2_q == smie_pkg::T_LONG) st = smie_pkg::ST_TYPE;
        else pops = 2'd2;
      end
      smie_pkg::CMD_DUP: begin
        if (sp_q < SpW'(1)) st = smie_pkg::ST_UNDER;
        else if (full) st = smie_pkg::ST_OVER;
        else if (t1_q == smie_pkg::T_LONG) st = smie_pkg::ST_TYPE;
        else begin push = 1'b1; pv = v1_q; pt = t1_q; end
      end
      smie_pkg::CMD_IFEQ, smie_pkg::CMD_IFNE, smie_pkg::CMD_IFLT,
      smie_pkg::CMD_IFLE, smie_pkg::CMD_IFGT, smie_pkg::CMD_IFGE: begin
        if (sp_q < SpW'(2)) st = smie_pkg::ST_UNDER;
        else if (t1_q != smie_pkg::T_INT || t2_q != smie_pkg::T_INT) st = smie_pkg::ST_TYPE;
        else begin
          pops = 2'd2;
          case (cmd_q)
            smie_pkg::CMD_IFEQ: tk = eq;
            smie_pkg::CMD_IFNE: tk = !eq;
            smie_pkg::CMD_IFLT: tk = lt_s;
            smie_pkg::CMD_IFLE: tk = lt_s || eq;
            smie_pkg::CMD_IFGT: tk = !lt_s && !eq;
            default:            tk = !lt_s;
          endcase
        end
      end
      smie_pkg::CMD_GOTO: tk = 1'b1;
      default: st = smie_pkg::ST_UNKNOWN;
    endcase
  end

  logic [SpW-1:0] sp_new;
  assign sp_new = sp_q - SpW'(pops);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locals_q <= 5'd16;
      sp_q <= '0;
      for (int k = 0; k < smie_pkg::StackDepth; k++) stt_q[k] <= smie_pkg::T_EMPTY;
      for (int k = 0; k < smie_pkg::LocalSlots; k++) begin
        lv_q[k] <= '0;
        lt_q[k] <= smie_pkg::T_EMPTY;
      end
    end else begin
      if (cfg_we_i) locals_q <= cfg_wdata_i;
      if (cmd_i.execute) begin
        if (wr_loc) begin
          lv_q[li] <= v1_q;
          lt_q[li] <= t1_q;
        end
        if (iinc) lv_q[li] <= {32'd0, lval_q[31:0] + imm_q};
        if (push) stt_q[SIdxW'(sp_new)] <= pt;
        sp_q <= sp_new + SpW'(push);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      idx_q <= local_index_i;
      imm_q <= immediate_i;
    end
    if (cmd_i.fetch) begin
      v1_q <= stk_q[i1];
      v2_q <= stk_q[i2];
      t1_q <= (sp_q >= SpW'(1)) ? stt_q[i1] : smie_pkg::T_EMPTY;
      t2_q <= (sp_q >= SpW'(2)) ? stt_q[i2] : smie_pkg::T_EMPTY;
      lok_q <= 9'(idx_q) < lim;
      lval_q <= lv_q[li];
      ltyp_q <= lt_q[li];
      mcnt_q <= 2'd0;
      macc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      mcnt_q <= mcnt_q + 2'd1;
      case (mcnt_q)
        2'd0: macc_q <= macc_q + prod;
        2'd3: macc_q <= macc_q;
        default: macc_q <= macc_q + {prod[31:0], 32'd0};
      endcase
    end
    if (cmd_i.execute) begin
      if (push) stk_q[SIdxW'(sp_new)] <= pv;
      st_q <= st;
      tk_q <= tk;
      off_q <= tk ? imm_q : 32'd0;
    end
  end

  logic [SIdxW-1:0] ti;
  assign ti = SIdxW'(sp_q - SpW'(1));
  assign status_o = st_q;
  assign branch_taken_o = tk_q;
  assign branch_offset_o = off_q;
  assign top_value_o = (sp_q != '0) ? stk_q[ti] : 64'd0;
  assign top_type_o = (sp_q != '0) ? stt_q[ti] : smie_pkg::T_EMPTY;
  assign stack_depth_o = 5'(sp_q);

`ifndef NO_ASSERTIONS
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(smie_pkg::StackDepth))
    else $error("stack pointer beyond depth");
  a_sp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(sp_q))
    else $error("stack pointer moved outside execute");
  a_fault_noop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && st != smie_pkg::ST_OK) |=> $stable(sp_q) && !tk_q)
    else $error("faulting command changed state");
`endif

endmodule

// ----- sv/stack_machine_integer_execute.sv -----
// lmul builds its 64-bit result from three 32x32 partial products on one
// multiplier, stepping through S_MUL before the result is presented.
// One command at a time; the next is taken the cycle after the result transaction.
// Reset (rst_ni low, asynchronous): empty stack, locals zero and untyped,
// locals_in_use 16.
module stack_machine_integer_execute (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         command_i,
  input  logic [7:0]         local_index_i,
  input  logic signed [31:0] immediate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               branch_taken_o,
  output logic signed [31:0] branch_offset_o,
  output logic [63:0]        top_value_o,
  output logic [1:0]         top_type_o,
  output logic [4:0]         stack_depth_o
);

  smie_pkg::cmd_t  cmd;
  smie_pkg::stat_t stat;

  smie_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  smie_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .cfg_we_i, .cfg_wdata_i,
    .command_i, .local_index_i, .immediate_i, .status_o, .branch_taken_o,
    .branch_offset_o, .top_value_o, .top_type_o, .stack_depth_o
  );

endmodule
